>>> design/pvm_pkg.sv
package pvm_pkg;

    localparam int VOICES_DEF      = 48;
    localparam int SAMPLE_RATE_DEF = 44100;
    localparam int ATTACK_DEF      = 64;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_NOTE = 1'b1;

    localparam logic [2:0] WAVE_SINE   = 3'd0;
    localparam logic [2:0] WAVE_SQUARE = 3'd1;
    localparam logic [2:0] WAVE_SAW    = 3'd2;
    localparam logic [2:0] WAVE_TRI    = 3'd3;
    localparam logic [2:0] WAVE_NOISE  = 3'd4;

    localparam logic [23:0] ENV_FULL   = 24'hFFFFFF;
    localparam logic [23:0] ENV_FLOOR  = 24'd16778;
    localparam logic [15:0] AMP_SQUARE = 16'd19661;
    localparam logic [15:0] AMP_SAW    = 16'd22938;
    localparam logic [15:0] AMP_NOISE  = 16'd19661;
    localparam logic [16:0] SIN_A      = 17'd51472;
    localparam logic [15:0] SIN_B      = 16'd21024;
    localparam logic [15:0] SIN_C      = 16'd2320;
    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;

    // top octave in 1/256 Hz
    localparam logic [21:0] TOP_HZ256 [12] = '{
        22'd2143237, 22'd2270680, 22'd2405702, 22'd2548752, 22'd2700309, 22'd2860878,
        22'd3030994, 22'd3211227, 22'd3402176, 22'd3604480, 22'd3818814, 22'd4045892
    };

    // 0.85 * tanh(k/4), Q0.15
    localparam logic [14:0] TANH_TAB [17] = '{
        15'd0, 15'd6822, 15'd12871, 15'd17691, 15'd21213, 15'd23627, 15'd25211,
        15'd26220, 15'd26851, 15'd27241, 15'd27480, 15'd27626, 15'd27715,
        15'd27769, 15'd27802, 15'd27822, 15'd27834
    };

endpackage

>>> design/pvm_cdiv.sv
module pvm_cdiv #(
    parameter int DIVISOR = 10,
    parameter int NW      = 34,
    parameter int QW      = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    output logic          o_done,
    output logic [QW-1:0] o_quotient
);
    // floor(n / DIVISOR) = n * ceil(2^K / DIVISOR) >> K, K = NW + clog2(DIVISOR);
    // the product is built 16 dividend bits per cycle, top chunk first
    localparam int          LW  = $clog2(DIVISOR);
    localparam int          K   = NW + LW;
    localparam int          MB  = NW + 1;
    localparam logic [63:0] RCP = ((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MB-1:0] M = MB'(RCP);
    localparam int          CH  = (NW + 15) / 16;
    localparam int          PW  = CH * 16;
    localparam int          AW  = PW + MB;
    localparam int          PPW = MB + 16;
    localparam int          CW  = $clog2(CH + 1);

    logic [PW-1:0]  r_n;
    logic [AW-1:0]  r_acc;
    logic [CW-1:0]  r_cnt;
    logic           r_run;
    logic           r_done;
    logic [PPW-1:0] w_pp;
    logic [AW-1:0]  w_acc_n;

    assign w_pp       = PPW'(M) * PPW'(r_n[PW-1 -: 16]);
    assign w_acc_n    = (r_acc << 16) + AW'(w_pp);
    assign o_done     = r_done;
    assign o_quotient = QW'(r_acc >> K);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_acc <= '0;
                r_n   <= PW'(i_dividend);
            end else if (r_run) begin
                r_acc <= w_acc_n;
                r_n   <= r_n << 16;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(CH - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> design/pvm_soft_clip.sv
module pvm_soft_clip #(
    parameter int MW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [MW-1:0] i_mix,
    output logic                 o_done,
    output logic signed [15:0]   o_sample
);
    import pvm_pkg::*;

    localparam int NW = MW + 4;
    localparam logic [NW-1:0] SAT_LIM = NW'(10) << 26;

    typedef enum logic [2:0] {C_IDLE, C_CHK, C_DIV, C_INT, C_SUM, C_OUT} t_cstate;

    t_cstate       r_state;
    logic [NW-1:0] r_n;
    logic          r_neg;
    logic [25:0]   r_x;
    logic [36:0]   r_prod;
    logic [14:0]   r_base;
    logic [15:0]   r_y;
    logic          r_done;
    logic [15:0]   r_sample;
    logic [MW-1:0] w_abs;
    logic [14:0]   w_diff;
    logic [4:0]    w_idx;
    logic          w_div_done;
    logic [25:0]   w_q;
    logic [36:0]   w_rnd;

    assign w_abs  = i_mix[MW-1] ? MW'(-i_mix) : MW'(i_mix);
    assign w_idx  = {1'b0, r_x[25:22]};
    assign w_diff = TANH_TAB[w_idx + 5'd1] - TANH_TAB[w_idx];
    assign w_rnd  = r_prod + 37'h200000;

    pvm_cdiv #(.DIVISOR(10), .NW(NW), .QW(26)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == C_CHK && r_n < SAT_LIM),
        .i_dividend (r_n),
        .o_done     (w_div_done),
        .o_quotient (w_q)
    );

    assign o_done   = r_done;
    assign o_sample = r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: if (i_start) begin
                    r_neg   <= i_mix[MW-1];
                    r_n     <= NW'(w_abs) * NW'(9);
                    r_state <= C_CHK;
                end
                C_CHK: begin
                    if (r_n >= SAT_LIM) begin
                        r_y     <= {1'b0, TANH_TAB[16]};
                        r_state <= C_OUT;
                    end else begin
                        r_state <= C_DIV;
                    end
                end
                C_DIV: if (w_div_done) begin
                    r_x     <= w_q;
                    r_state <= C_INT;
                end
                C_INT: begin
                    r_prod  <= 37'(w_diff) * 37'(r_x[21:0]);
                    r_base  <= TANH_TAB[w_idx];
                    r_state <= C_SUM;
                end
                C_SUM: begin
                    r_y     <= {1'b0, r_base} + 16'(w_rnd >> 22);
                    r_state <= C_OUT;
                end
                C_OUT: begin
                    r_sample <= r_neg ? 16'(-r_y) : r_y;
                    r_done   <= 1'b1;
                    r_state  <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

>>> design/polyphonic_voice_mixer_unit.sv
// Note-on: scans for the lowest free voice; no result.
// Tick: each voice is checked and each active voice runs the datapath (plus the
//   reciprocal-multiply gain divide while in attack), then the soft clip (which skips
//   its divide once the mix is past table range); one o_strobe pulse.
// Throughput: one item at a time; busy stays high until the item is finished.
// Reset: synchronous, active low; clears control state, active and seed-valid bits.
// The receiver cannot stall: o_sample is valid only in the o_strobe cycle.
module polyphonic_voice_mixer_unit #(
    parameter int VOICES         = pvm_pkg::VOICES_DEF,
    parameter int SAMPLE_RATE    = pvm_pkg::SAMPLE_RATE_DEF,
    parameter int ATTACK_SAMPLES = pvm_pkg::ATTACK_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [6:0]         i_note,
    input  logic [2:0]         i_waveform,
    input  logic [15:0]        i_volume,
    input  logic [23:0]        i_decay_factor,
    input  logic [24:0]        i_slide_factor,
    output logic               o_strobe,
    output logic signed [15:0] o_sample
);
    import pvm_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW = $clog2(ATTACK_SAMPLES + 1);
    localparam int GW = 24 + AW;
    // per-voice contribution is under 2^25 in magnitude
    localparam int MW = 26 + $clog2(VOICES + 1);

    // one memory word holds a voice's tick state except its noise seed and active bit
    typedef struct packed {
        logic [2:0]    wave;
        logic [31:0]   phase;
        logic [31:0]   inc;
        logic [24:0]   slide;
        logic [15:0]   vol;
        logic [23:0]   env;
        logic [23:0]   decay;
        logic [AW-1:0] att;
    } t_voice;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_RD, S_A, S_B, S_C, S_D, S_E, S_F, S_G,
        S_M1, S_M2, S_INC, S_ENV, S_WB, S_CLIP
    } t_state;

    // note ROM: increment = round(hz256 * 2^24 / (rate * 2^(10 - octave))), saturated
    logic [31:0] w_rom [128];
    for (genvar g = 0; g < 128; g++) begin : g_rom
        localparam int          OCT  = g / 12;
        localparam int          SEMI = g % 12;
        localparam logic [63:0] DEN  = 64'(SAMPLE_RATE) << (10 - OCT);
        localparam logic [63:0] NUM  = 64'(TOP_HZ256[SEMI]) << 24;
        localparam logic [63:0] QV   = (NUM + DEN / 2) / DEN;
        assign w_rom[g] = (QV > 64'hFFFFFFFF) ? 32'hFFFFFFFF : QV[31:0];
    end

    // control
    t_state               r_state;
    logic [VW-1:0]        r_v;
    logic [VOICES-1:0]    r_active;
    logic [VOICES-1:0]    r_seed_ok;
    logic signed [MW-1:0] r_mix;
    logic                 r_clip_go;

    // latched note-on fields
    logic [6:0]  r_note;
    logic [2:0]  r_wave;
    logic [15:0] r_vol;
    logic [23:0] r_decay;
    logic [24:0] r_slide;

    // voice store and noise-seed store, registered reads
    t_voice      r_mem [VOICES];
    t_voice      r_rd;
    logic [31:0] r_seed_mem [VOICES];
    logic [31:0] r_seed_rd;
    logic        w_we;
    t_voice      w_wdata;
    logic        w_seed_we;

    // datapath registers, one multiply per stage
    logic [31:0]   r_p1;
    logic [31:0]   r_p2;
    logic [31:0]   r_p3;
    logic [31:0]   r_p4;
    logic [31:0]   r_seed_n;
    logic [15:0]   r_smag;
    logic          r_sneg;
    logic [GW-1:0] r_gp;
    logic [23:0]   r_gain;
    logic [55:0]   r_mag;
    logic [56:0]   r_incp;
    logic [47:0]   r_envp;

    // combinational views of the voice being processed
    logic [15:0]        w_zraw;
    logic [15:0]        w_z;
    logic signed [15:0] w_d;
    logic [15:0]        w_dabs;
    logic [31:0]        w_seed;
    logic [15:0]        w_z2;
    logic [15:0]        w_t1;
    logic [16:0]        w_t2;
    logic [15:0]        w_nabs;
    logic [16:0]        w_sine;
    logic               w_att_live;
    logic               w_last;
    logic [24:0]        w_vmag;
    logic [57:0]        w_inc_r;
    logic [31:0]        w_inc_n;
    logic [23:0]        w_env_n;
    logic               w_gdiv_done;
    logic [23:0]        w_gdiv_q;
    logic               w_clip_done;

    assign w_zraw = {1'b0, r_rd.phase[29:15]};
    assign w_z    = r_rd.phase[30] ? 16'd32768 - w_zraw : w_zraw;
    // (phase >> 16) - 32768 is the top half with its MSB flipped
    assign w_d    = {~r_rd.phase[31], r_rd.phase[30:16]};
    assign w_dabs = w_d[15] ? 16'(~w_d + 16'sd1) : 16'(w_d);
    assign w_seed = r_seed_ok[r_v] ? r_seed_rd : 32'd0;
    assign w_z2   = r_p1[30:15];
    assign w_t1   = SIN_B - 16'(r_p2 >> 15);
    assign w_t2   = SIN_A - 17'(r_p3 >> 15);
    assign w_nabs = r_seed_n[31] ? 16'(~r_seed_n[31:16] + 16'd1) : r_seed_n[31:16];
    assign w_sine = 17'(r_p4 >> 15);

    assign w_att_live = r_rd.att < AW'(ATTACK_SAMPLES);
    assign w_last     = r_v == VW'(VOICES - 1);
    assign w_vmag     = 25'((r_mag + 56'h40000000) >> 31);
    assign w_inc_r    = 58'(r_incp) + 58'h800000;
    assign w_inc_n    = (|w_inc_r[57:56]) ? 32'hFFFFFFFF : w_inc_r[55:24];
    assign w_env_n    = r_envp[47:24];

    assign busy = r_state != S_IDLE;

    // gain = envelope * attack / ATTACK_SAMPLES during the attack ramp
    pvm_cdiv #(.DIVISOR(ATTACK_SAMPLES), .NW(GW), .QW(24)) u_gain_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_F && w_att_live),
        .i_dividend (r_gp),
        .o_done     (w_gdiv_done),
        .o_quotient (w_gdiv_q)
    );

    pvm_soft_clip #(.MW(MW)) u_clip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_clip_go),
        .i_mix    (r_mix),
        .o_done   (w_clip_done),
        .o_sample (o_sample)
    );
    assign o_strobe = w_clip_done;

    // write-back data: a fresh voice on note-on, the advanced voice on a tick
    always_comb begin
        w_we      = 1'b0;
        w_seed_we = 1'b0;
        w_wdata   = r_rd;
        if (r_state == S_SCAN && !r_active[r_v]) begin
            w_we          = 1'b1;
            w_wdata.wave  = r_wave;
            w_wdata.phase = 32'd0;
            w_wdata.inc   = w_rom[r_note];
            w_wdata.slide = r_slide;
            w_wdata.vol   = r_vol;
            w_wdata.env   = ENV_FULL;
            w_wdata.decay = r_decay;
            w_wdata.att   = '0;
        end else if (r_state == S_WB) begin
            w_we          = 1'b1;
            w_seed_we     = r_rd.wave == WAVE_NOISE;
            w_wdata.phase = r_rd.phase + r_rd.inc;
            w_wdata.inc   = w_inc_n;
            w_wdata.env   = w_env_n;
            w_wdata.att   = w_att_live ? r_rd.att + 1'b1 : r_rd.att;
        end
    end

    // the address is always the current voice; a voice is read, worked on and
    // written back before the next one is addressed, so accesses never overlap
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[r_v] <= w_wdata;
        if (w_seed_we) r_seed_mem[r_v] <= r_seed_n;
        r_rd      <= r_mem[r_v];
        r_seed_rd <= r_seed_mem[r_v];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_v       <= '0;
            r_active  <= '0;
            r_seed_ok <= '0;
            r_mix     <= '0;
            r_clip_go <= 1'b0;
        end else begin
            r_clip_go <= 1'b0;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_v     <= '0;
                    r_mix   <= '0;
                    r_note  <= i_note;
                    r_wave  <= i_waveform;
                    r_vol   <= i_volume;
                    r_decay <= i_decay_factor;
                    r_slide <= i_slide_factor;
                    r_state <= (i_kind == KIND_NOTE) ? S_SCAN : S_RD;
                end
                // first free voice wins; with none free the note is dropped
                S_SCAN: begin
                    if (!r_active[r_v]) begin
                        r_active[r_v] <= 1'b1;
                        r_state       <= S_IDLE;
                    end else if (w_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_RD: begin
                    if (r_active[r_v]) begin
                        r_state <= S_A;
                    end else if (w_last) begin
                        r_clip_go <= 1'b1;
                        r_state   <= S_CLIP;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_A: begin
                    unique case (r_rd.wave)
                        WAVE_SINE:  r_p1 <= 32'(w_z) * 32'(w_z);
                        WAVE_SAW:   r_p1 <= 32'(w_dabs) * 32'(AMP_SAW);
                        WAVE_NOISE: r_seed_n <= w_seed * LCG_MUL + LCG_ADD;
                        default:    r_p1 <= r_p1;
                    endcase
                    r_state <= S_B;
                end
                S_B: begin
                    if (r_rd.wave == WAVE_NOISE) r_p2 <= 32'(w_nabs) * 32'(AMP_NOISE);
                    else                         r_p2 <= 32'(w_z2) * 32'(SIN_C);
                    r_state <= S_C;
                end
                S_C: begin
                    r_p3    <= 32'(w_z2) * 32'(w_t1);
                    r_state <= S_D;
                end
                S_D: begin
                    r_p4    <= 32'(w_z) * 32'(w_t2);
                    r_state <= S_E;
                end
                // wave value as magnitude and sign
                S_E: begin
                    unique case (r_rd.wave)
                        WAVE_SINE: begin
                            r_smag <= (w_sine > 17'd32767) ? 16'd32767 : w_sine[15:0];
                            r_sneg <= r_rd.phase[31];
                        end
                        WAVE_SQUARE: begin
                            r_smag <= AMP_SQUARE;
                            r_sneg <= r_rd.phase[31];
                        end
                        WAVE_SAW: begin
                            r_smag <= 16'((r_p1 + 32'd16384) >> 15);
                            r_sneg <= w_d[15];
                        end
                        WAVE_TRI: begin
                            if (w_dabs >= 16'd16384) begin
                                r_smag <= (w_dabs == 16'd32768) ? 16'd32767
                                                                : 16'({w_dabs, 1'b0} - 17'd32768);
                                r_sneg <= 1'b0;
                            end else begin
                                r_smag <= 16'd32768 - {w_dabs[14:0], 1'b0};
                                r_sneg <= 1'b1;
                            end
                        end
                        WAVE_NOISE: begin
                            r_smag <= 16'((r_p2 + 32'd16384) >> 15);
                            r_sneg <= r_seed_n[31];
                        end
                        default: begin
                            r_smag <= 16'd0;
                            r_sneg <= 1'b0;
                        end
                    endcase
                    r_gp    <= GW'(r_rd.env) * GW'(r_rd.att);
                    r_state <= S_F;
                end
                S_F: begin
                    if (w_att_live) begin
                        r_state <= S_G;
                    end else begin
                        r_gain  <= r_rd.env;
                        r_state <= S_M1;
                    end
                end
                S_G: if (w_gdiv_done) begin
                    r_gain  <= w_gdiv_q;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_p1    <= 32'(r_smag) * 32'(r_rd.vol);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_mag   <= 56'(r_p1) * 56'(r_gain);
                    r_state <= S_INC;
                end
                S_INC: begin
                    r_mix   <= r_sneg ? r_mix - MW'(w_vmag) : r_mix + MW'(w_vmag);
                    r_incp  <= 57'(r_rd.inc) * 57'(r_rd.slide);
                    r_state <= S_ENV;
                end
                S_ENV: begin
                    r_envp  <= 48'(r_rd.env) * 48'(r_rd.decay);
                    r_state <= S_WB;
                end
                // voice turns off once its envelope falls below the floor
                S_WB: begin
                    r_active[r_v] <= w_env_n >= ENV_FLOOR;
                    if (r_rd.wave == WAVE_NOISE) r_seed_ok[r_v] <= 1'b1;
                    if (w_last) begin
                        r_clip_go <= 1'b1;
                        r_state   <= S_CLIP;
                    end else begin
                        r_v     <= r_v + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_CLIP: if (w_clip_done) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/pvm_checker.sv
module pvm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_kind,
    input logic o_strobe
);
    import pvm_pkg::*;

    // a result only shows up while an item is being worked on
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy) else $error("strobe while idle");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after transfer");

    a_note_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_NOTE) |=> !o_strobe)
        else $error("note-on produced a sample");

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("strobe longer than one cycle");

    a_strobe_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy) else $error("busy after sample");

endmodule

bind polyphonic_voice_mixer_unit pvm_checker u_pvm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_kind   (i_kind),
    .o_strobe (o_strobe)
);

>>> verif/polyphonic_voice_mixer_unit_test.sv
module polyphonic_voice_mixer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pvm_pkg::*;

    localparam int NVOICE = 48;
    localparam int RATE = 44100;
    localparam int RAMP = 64;
    localparam logic [24:0] SLIDE_NONE = 25'd16777216;

    // Predictor constants kept local so they do not lean on the DUT package.
    localparam logic [31:0] NOTE_TOP [12] = '{
        32'd2143237, 32'd2270680, 32'd2405702, 32'd2548752, 32'd2700309, 32'd2860878,
        32'd3030994, 32'd3211227, 32'd3402176, 32'd3604480, 32'd3818814, 32'd4045892
    };
    localparam int TANH_Q15 [17] = '{
        0, 6822, 12871, 17691, 21213, 23627, 25211, 26220, 26851,
        27241, 27480, 27626, 27715, 27769, 27802, 27822, 27834
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_kind = KIND_TICK;
    logic [6:0] i_note = '0;
    logic [2:0] i_waveform = '0;
    logic [15:0] i_volume = '0;
    logic [23:0] i_decay_factor = '0;
    logic [24:0] i_slide_factor = '0;
    logic o_strobe;
    logic signed [15:0] o_sample;

    polyphonic_voice_mixer_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_note(i_note), .i_waveform(i_waveform),
        .i_volume(i_volume), .i_decay_factor(i_decay_factor),
        .i_slide_factor(i_slide_factor), .o_strobe(o_strobe), .o_sample(o_sample)
    );

    always #5 i_clk = ~i_clk;

    // Shadow voice bank
    bit          vc_on    [NVOICE];
    logic [2:0]  vc_wave  [NVOICE];
    logic [31:0] vc_phase [NVOICE];
    logic [31:0] vc_inc   [NVOICE];
    logic [24:0] vc_slide [NVOICE];
    logic [15:0] vc_vol   [NVOICE];
    logic [23:0] vc_env   [NVOICE];
    logic [23:0] vc_decay [NVOICE];
    int          vc_ramp  [NVOICE];
    logic [31:0] vc_seed  [NVOICE];

    logic signed [15:0] sample_queue[$];
    int  fail_count = 0;
    bit  gaps_on = 1'b1;

    function automatic longint round_q15(longint p);
        longint m;
        m = (p < 0) ? -p : p;
        m = (m + 16384) >>> 15;
        return (p < 0) ? -m : m;
    endfunction

    function automatic logic [31:0] rom_increment(int n);
        longint unsigned den, num, q;
        den = longint'(RATE) << (10 - n / 12);
        num = longint'(NOTE_TOP[n % 12]) << 24;
        q = (num + den / 2) / den;
        return (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
    endfunction

    function automatic longint sine_value(logic [31:0] ph);
        longint unsigned z, z2, t, y;
        z = (ph >> 15) & 32'h7FFF;
        if (ph[31:30] == 2'd1 || ph[31:30] == 2'd3) z = 32768 - z;
        z2 = (z * z) >> 15;
        t = 21024 - ((z2 * 2320) >> 15);
        t = 51472 - ((z2 * t) >> 15);
        y = (z * t) >> 15;
        if (y > 32767) y = 32767;
        return ph[31] ? -longint'(y) : longint'(y);
    endfunction

    function automatic longint wave_out(int v);
        longint d, t;
        d = longint'(vc_phase[v] >> 16) - 32768;
        case (vc_wave[v])
            WAVE_SINE:   return sine_value(vc_phase[v]);
            WAVE_SQUARE: return vc_phase[v][31] ? -19661 : 19661;
            WAVE_SAW:    return round_q15(d * 22938);
            WAVE_TRI: begin
                t = 2 * ((d < 0) ? -d : d) - 32768;
                return (t > 32767) ? 32767 : t;
            end
            WAVE_NOISE: begin
                vc_seed[v] = vc_seed[v] * 32'd1664525 + 32'd1013904223;
                return round_q15(longint'($signed(vc_seed[v][31:16])) * 19661);
            end
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [15:0] clip_mix(longint mix);
        longint unsigned a, x, idx, frac;
        longint y;
        a = (mix < 0) ? -mix : mix;
        x = a * 9 / 10;
        idx = x >> 22;
        frac = x & 64'h3FFFFF;
        if (idx >= 16) y = TANH_Q15[16];
        else y = TANH_Q15[idx] +
            longint'((longint'(TANH_Q15[idx + 1] - TANH_Q15[idx]) * frac + 64'h200000) >> 22);
        return 16'((mix < 0) ? -y : y);
    endfunction

    // Apply one transfer to the shadow bank; a tick queues the expected sample.
    function automatic void predict_voices(logic kind, logic [6:0] note, logic [2:0] wave,
                                           logic [15:0] vol, logic [23:0] dec,
                                           logic [24:0] sl);
        longint mix, s;
        longint unsigned gain, mag, inc;
        mix = 0;
        if (kind == KIND_NOTE) begin
            for (int v = 0; v < NVOICE; v++) begin
                if (!vc_on[v]) begin
                    vc_on[v] = 1'b1;
                    vc_wave[v] = wave;
                    vc_phase[v] = '0;
                    vc_inc[v] = rom_increment(note);
                    vc_slide[v] = sl;
                    vc_vol[v] = vol;
                    vc_env[v] = 24'hFFFFFF;
                    vc_decay[v] = dec;
                    vc_ramp[v] = 0;
                    return;
                end
            end
            return;
        end
        for (int v = 0; v < NVOICE; v++) begin
            if (!vc_on[v]) continue;
            s = wave_out(v);
            gain = vc_env[v];
            if (vc_ramp[v] < RAMP) begin
                gain = gain * vc_ramp[v] / RAMP;
                vc_ramp[v]++;
            end
            mag = longint'((s < 0) ? -s : s) * vc_vol[v] * gain;
            mag = (mag + 64'h40000000) >> 31;
            mix += (s < 0) ? -longint'(mag) : longint'(mag);
            vc_phase[v] = vc_phase[v] + vc_inc[v];
            inc = (longint'(vc_inc[v]) * vc_slide[v] + 64'h800000) >> 24;
            vc_inc[v] = (inc > 64'hFFFFFFFF) ? 32'hFFFFFFFF : inc[31:0];
            vc_env[v] = 24'((longint'(vc_env[v]) * vc_decay[v]) >> 24);
            if (vc_env[v] < 24'd16778) vc_on[v] = 1'b0;
        end
        sample_queue.insert(sample_queue.size(), clip_mix(mix));
    endfunction

    // Result checker: every strobe must match the oldest expected sample.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (sample_queue.size() == 0) begin
                $error("sample: unexpected strobe, actual %0d", o_sample);
                fail_count++;
            end else begin
                if (o_sample !== sample_queue[0]) begin
                    $error("sample: expected %0d actual %0d", sample_queue[0], o_sample);
                    fail_count++;
                end
                void'(sample_queue.pop_front());
            end
        end
    end

    // One transfer: optional gap, present fields, wait until busy falls.
    task automatic send_item(logic kind, logic [6:0] note, logic [2:0] wave, logic [15:0] vol,
                             logic [23:0] dec, logic [24:0] sl);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        start <= 1'b1;
        i_kind <= kind;
        i_note <= note;
        i_waveform <= wave;
        i_volume <= vol;
        i_decay_factor <= dec;
        i_slide_factor <= sl;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_voices(kind, note, wave, vol, dec, sl);
        @(negedge i_clk);
    endtask

    task automatic tick();
        send_item(KIND_TICK, 7'($urandom), 3'($urandom), 16'($urandom), 24'($urandom),
                  25'($urandom));
    endtask

    task automatic note_on(logic [6:0] n, logic [2:0] w, logic [15:0] vol, logic [23:0] dec,
                           logic [24:0] sl);
        send_item(KIND_NOTE, n, w, vol, dec, sl);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (sample_queue.size() != 0) @(negedge i_clk);
    endtask

    // Each waveform, note extremes, silent codes, fast decay, wild slide.
    task automatic test_directed();
        note_on(7'd0, WAVE_SINE, 16'hFFFF, 24'hFFFFFF, SLIDE_NONE);
        note_on(7'd127, WAVE_SQUARE, 16'hFFFF, 24'hFFF000, 25'd0);
        note_on(7'd69, WAVE_SAW, 16'h8000, 24'hFFF800, SLIDE_NONE);
        note_on(7'd60, WAVE_TRI, 16'hFFFF, 24'hFFFF00, 25'd16800000);
        note_on(7'd45, WAVE_NOISE, 16'hFFFF, 24'hFFFFFF, SLIDE_NONE);
        note_on(7'd100, 3'd5, 16'hFFFF, 24'hFFFFFF, SLIDE_NONE);
        note_on(7'd90, 3'd7, 16'd0, 24'd0, 25'h1FFFFFF);
        note_on(7'd126, WAVE_SAW, 16'hFFFF, 24'hFFFFFF, 25'h1FFFFFF);
        repeat (16) tick();
        drain();
    endtask

    // Fill all voices loud to push the clip past table range, then drop extra notes.
    task automatic test_full_bank();
        for (int k = 0; k < NVOICE + 6; k++)
            note_on(7'($urandom_range(40, 90)), WAVE_SQUARE, 16'hFFFF, 24'hFFFFF0, SLIDE_NONE);
        repeat (70) tick();
        drain();
    endtask

    // Mostly well-formed play: short-decay notes mixed with ticks, random content.
    task automatic test_random(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0)
                note_on(7'($urandom), 3'($urandom_range(0, 7)), 16'($urandom),
                        ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                                    : 24'($urandom_range(24'hF00000, 24'hFFFFFF)),
                        ($urandom_range(0, 3) == 0) ? 25'($urandom)
                                                    : 25'($urandom_range(16700000, 16850000)));
            else
                tick();
        end
    endtask

    initial begin
        for (int v = 0; v < NVOICE; v++) begin
            vc_on[v] = 1'b0;
            vc_seed[v] = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_full_bank();
        test_random(900);
        drain();                 // sender holds off until every sample is back
        gaps_on = 1'b0;
        test_random(350);

        drain();
        repeat (300) @(negedge i_clk);
        if (fail_count == 0 && sample_queue.size() == 0)
            $display("[polyphonic_voice_mixer_unit] OK");
        else
            $display("[polyphonic_voice_mixer_unit] ERROR");
        $finish;
    end

    // Watchdog: the worst-case tick time plus gaps, with ample margin.
    initial begin
        #60ms;
        $display("[polyphonic_voice_mixer_unit] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
design/pvm_pkg.sv
design/pvm_cdiv.sv
design/pvm_soft_clip.sv
design/polyphonic_voice_mixer_unit.sv
design/pvm_checker.sv
verif/polyphonic_voice_mixer_unit_test.sv
